### design/setx_pkg.sv
`timescale 1ns / 1ps
// Package for the sprite entry tile expander: state type, field widths and
// the zoom step table. No dependencies.
package setx_pkg;

  localparam int MaxTilesPerSide = 8;
  localparam int TileIdxW = $clog2(MaxTilesPerSide);
  localparam int PosW = 11;
  localparam int StepW = 5;
  localparam int CoordW = 9;
  localparam int InDataW = 64;
  localparam int OutDataW = 56;

  localparam logic [CoordW-1:0] ResetMaxX = 9'd319;
  localparam logic [CoordW-1:0] ResetMaxY = 9'd239;

  typedef enum logic {
    CFG_MAX_X = 1'b0,
    CFG_MAX_Y = 1'b1
  } cfg_index_t;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  typedef logic signed [PosW-1:0] pos_t;

  // 16 - zoom_table[idx] / 8
  function automatic logic [StepW-1:0] zoom_step(input logic [3:0] idx);
    logic [StepW-1:0] s;
    case (idx)
      4'd0, 4'd1:        s = 5'd16;
      4'd2:              s = 5'd15;
      4'd3:              s = 5'd14;
      4'd4, 4'd5:        s = 5'd13;
      4'd6, 4'd7:        s = 5'd12;
      4'd8, 4'd9:        s = 5'd11;
      4'd10, 4'd11, 4'd12: s = 5'd10;
      default:           s = 5'd9;
    endcase
    return s;
  endfunction

  // 9-bit position minus 8, moved back by 512 when past the visible edge
  function automatic pos_t decode_pos(input logic [CoordW-1:0] raw,
                                      input logic [CoordW-1:0] vmax);
    pos_t p;
    p = pos_t'({2'b00, raw}) - pos_t'(8);
    if (p > pos_t'({2'b00, vmax})) begin
      p = p - pos_t'(512);
    end
    return p;
  endfunction

  // clamp field + 1 to the side limit, return count - 1
  function automatic logic [TileIdxW-1:0] tile_last(input logic [2:0] field);
    logic [3:0] n;
    n = {1'b0, field} + 4'd1;
    if (n > 4'(MaxTilesPerSide)) begin
      n = 4'(MaxTilesPerSide);
    end
    return TileIdxW'(n - 4'd1);
  endfunction

endpackage

### design/sprite_entry_tile_expander_unit.sv
`timescale 1ns / 1ps
// Sprite entry tile expander: decodes one attribute entry and walks its tile grid.
// Depends on setx_pkg.
//
// One attribute entry is taken per sprite; a disabled entry (bit 7 of word 2
// clear) is dropped in its accept cycle. An enabled entry is decoded in the
// accept cycle and then a row/column sequencer drives a shared pair of
// multiply-add units, one per axis (offset index times tile pitch plus base
// position), which produce one draw command per cycle in row-major order while
// the output is not stalled. An entry of W by H tiles holds the input off
// until all its commands are loaded, so enabled entries wait for the whole
// walk (longer under output stalls) and disabled ones can follow every cycle.
// The final command of a sprite is marked with tlast, and the next entry may
// be accepted while that command still waits in the output register.
module sprite_entry_tile_expander_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [setx_pkg::CoordW-1:0]    cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // attr_word0 [15:0], attr_word1 [31:16], attr_word2 [47:32], attr_word3 [63:48]
  input  logic [setx_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // tile_code [15:0], palette_color [19:16], flip_x [20], flip_y [21],
  // pos_x [32:22], pos_y [43:33], zoom_enabled [44], step_x [49:45],
  // step_y [54:50], zero [55]
  output logic [setx_pkg::OutDataW-1:0]  m_tdata,
  output logic                           m_tlast
);
  import setx_pkg::*;

  logic [CoordW-1:0] max_x;
  logic [CoordW-1:0] max_y;

  state_t state;
  state_t state_next;

  pos_t base_x;
  pos_t base_y;
  logic [StepW-1:0] step_x;
  logic [StepW-1:0] step_y;
  logic [TileIdxW-1:0] xn1;
  logic [TileIdxW-1:0] yn1;
  logic [TileIdxW-1:0] col;
  logic [TileIdxW-1:0] row;
  logic flip_x;
  logic flip_y;
  logic zoomed;
  logic [3:0] color;
  logic [15:0] code;

  logic [15:0] w0, w1, w2, w3;
  logic s_accept;
  logic enabled;
  logic load;
  logic is_last;
  logic [TileIdxW-1:0] kx;
  logic [TileIdxW-1:0] ky;
  logic [TileIdxW+StepW-1:0] off_x;
  logic [TileIdxW+StepW-1:0] off_y;
  pos_t px;
  pos_t py;
  logic [3:0] zx;
  logic [3:0] zy;

  assign w0 = s_tdata[15:0];
  assign w1 = s_tdata[31:16];
  assign w2 = s_tdata[47:32];
  assign w3 = s_tdata[63:48];
  assign zy = w0[15:12];
  assign zx = w1[15:12];
  assign enabled = w2[7];
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_x <= ResetMaxX;
      max_y <= ResetMaxY;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_MAX_X: max_x <= cfg_data;
        CFG_MAX_Y: max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_accept && enabled) state_next = S_EMIT;
      S_EMIT: if (load && is_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    load = (state == S_EMIT) && (!m_tvalid || m_tready);
    is_last = (row == yn1) && (col == xn1);
  end

  // shared multiply-add units, one per axis
  always_comb begin
    kx = flip_x ? (xn1 - col) : col;
    ky = flip_y ? (yn1 - row) : row;
    off_x = kx * step_x;
    off_y = ky * step_y;
    px = base_x + pos_t'({3'b000, off_x});
    py = base_y + pos_t'({3'b000, off_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      base_x <= decode_pos(w1[8:0], max_x);
      base_y <= decode_pos(w0[8:0], max_y);
      zoomed <= (zx != 4'd0) || (zy != 4'd0);
      step_x <= zoom_step(zx);
      step_y <= zoom_step(zy);
      xn1 <= tile_last(w2[10:8]);
      yn1 <= tile_last(w2[14:12]);
      flip_x <= w2[11];
      flip_y <= w2[15];
      color <= w2[3:0];
      code <= w3;
      col <= '0;
      row <= '0;
    end else if (load) begin
      code <= code + 16'd1;
      if (col == xn1) begin
        col <= '0;
        row <= row + TileIdxW'(1);
      end else begin
        col <= col + TileIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {1'b0, step_y, step_x, zoomed, py, px, flip_y, flip_x, color, code};
      m_tlast <= is_last;
    end
  end

  a_grid_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (row <= yn1 && col <= xn1))
    else $error("tile counters past grid");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && is_last) |=> (state == S_IDLE && m_tvalid && m_tlast))
    else $error("last tile did not end the sprite");

  a_drop_disabled: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !enabled) |=> (state == S_IDLE))
    else $error("disabled entry started a walk");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    (load && !is_last) |=> (m_tvalid && !m_tlast && state == S_EMIT))
    else $error("tile command lost");

endmodule
